@@ src/trc_pkg.sv @@
// ----------------------------------------------------------------------------
// trc_pkg
// Types, codes and sizes shared by the threshold rule checker.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int RULE_COUNT = 32;
  localparam int RULE_IDX_W = $clog2(RULE_COUNT);

  localparam logic [1:0] OP_WRITE_CHECK = 2'd0;
  localparam logic [1:0] OP_READ_CHECK  = 2'd1;
  localparam logic [1:0] OP_LOAD_RULE   = 2'd2;
  localparam logic [1:0] OP_READ_COUNT  = 2'd3;

  localparam logic [2:0] CMP_LT = 3'd1;
  localparam logic [2:0] CMP_LE = 3'd2;
  localparam logic [2:0] CMP_EQ = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;
  localparam logic [2:0] CMP_NE = 3'd6;

  localparam logic KIND_EVENT    = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         rule_index;
    logic [31:0]        caller_pid;
    logic [31:0]        file_handle;
    logic signed [63:0] byte_count;
    logic [63:0]        now_ns;
    logic               new_active;
    logic [2:0]         new_compare;
    logic signed [63:0] new_threshold;
    logic [31:0]        new_handle_filter;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [31:0]        event_pid;
    logic [4:0]         event_rule;
    logic signed [63:0] event_observed;
    logic signed [63:0] event_threshold;
    logic [63:0]        event_time;
    logic [63:0]        read_checks;
    logic [63:0]        read_violations;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic               active;
    logic [2:0]         compare;
    logic signed [63:0] threshold;
    logic [31:0]        handle;
  } rule_t;

  typedef struct packed {
    logic                  en;
    logic [RULE_IDX_W-1:0] addr;
    rule_t                 rule;
  } rule_wr_t;

  typedef struct packed {
    logic inc_check;
    logic inc_viol;
  } cnt_upd_t;

endpackage

`default_nettype wire

@@ src/trc_chan_if.sv @@
// ----------------------------------------------------------------------------
// trc_chan_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface trc_in_if;
  logic              valid;
  logic              ready;
  trc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trc_out_if;
  logic               valid;
  logic               ready;
  trc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/threshold_rule_checker_core.sv @@
// ----------------------------------------------------------------------------
// threshold_rule_checker_core
// Rule table checker: walks rules, counts checks and violations, emits events.
// ----------------------------------------------------------------------------
// A load-rule or read-check item is handled in the cycle it is accepted, and
// the input stays ready. A counter read is accepted and then answered in the
// read state once the result register is free. A write-check item is accepted,
// then the sequencer visits all 32 rules in turn through the single table port
// and comparator, and a flush state emits the final event; the walk and the
// flush wait while the result side stalls with an event still pending.
// Events come out in rule order and the last one of a walk is marked.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_rule_checker_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  trc_in_if.sink      in_port,
  trc_out_if.source   out_port
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  localparam logic [trc_pkg::RULE_IDX_W-1:0] LAST_RULE =
    trc_pkg::RULE_IDX_W'(trc_pkg::RULE_COUNT - 1);

  logic [1:0]                     state_r, state_nxt;
  logic [trc_pkg::RULE_IDX_W-1:0] rix_r, rix_nxt;
  trc_pkg::in_item_t              item_r;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [trc_pkg::RULE_IDX_W-1:0] pend_rule_r, pend_rule_nxt;
  logic signed [63:0]             pend_thr_r, pend_thr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  trc_pkg::out_item_t             out_r, out_nxt;

  logic                           accept;
  logic                           slot_free;
  logic                           out_load;
  logic [trc_pkg::RULE_IDX_W-1:0] tbl_addr;
  trc_pkg::rule_t                 rd_rule;
  logic [63:0]                    rd_checks;
  logic [63:0]                    rd_viols;
  trc_pkg::cnt_upd_t              cnt_upd;
  trc_pkg::rule_wr_t              rule_wr;
  logic [2:0]                     cmp_code;
  logic signed [63:0]             cmp_value;
  logic                           pass;
  logic                           hit;
  logic                           fail;
  logic                           stall;

  assign in_port.ready  = state_r == ST_IDLE;
  assign accept         = in_port.valid && in_port.ready;
  assign slot_free      = !out_valid_r || out_port.ready;
  assign out_port.valid = out_valid_r;
  assign out_port.data  = out_r;

  assign hit   = rd_rule.active &&
                 (rd_rule.handle == '0 || rd_rule.handle == item_r.file_handle);
  assign fail  = !pass;
  assign stall = hit && fail && pend_valid_r && !slot_free;

  always_comb begin
    unique case (state_r)
      ST_WALK:  tbl_addr = rix_r;
      ST_READ:  tbl_addr = item_r.rule_index[trc_pkg::RULE_IDX_W-1:0];
      default:  tbl_addr = '0;
    endcase
  end

  assign cmp_code  = (state_r == ST_WALK) ? rd_rule.compare : trc_pkg::CMP_LE;
  assign cmp_value = (state_r == ST_WALK) ? item_r.byte_count
                                          : in_port.data.byte_count;

  always_comb begin
    rule_wr.en             = accept && in_port.data.opcode == trc_pkg::OP_LOAD_RULE;
    rule_wr.addr           = in_port.data.rule_index[trc_pkg::RULE_IDX_W-1:0];
    rule_wr.rule.active    = in_port.data.new_active;
    rule_wr.rule.compare   = in_port.data.new_compare;
    rule_wr.rule.threshold = in_port.data.new_threshold;
    rule_wr.rule.handle    = in_port.data.new_handle_filter;
  end

  always_comb begin
    cnt_upd = '0;
    if (state_r == ST_WALK) begin
      if (!stall) begin
        cnt_upd.inc_check = hit;
        cnt_upd.inc_viol  = hit && fail;
      end
    end else if (accept && in_port.data.opcode == trc_pkg::OP_READ_CHECK) begin
      cnt_upd.inc_check = rd_rule.active;
      cnt_upd.inc_viol  = rd_rule.active && fail;
    end
  end

  trc_rule_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (tbl_addr),
    .rd_rule   (rd_rule),
    .rd_checks (rd_checks),
    .rd_viols  (rd_viols),
    .cnt_upd   (cnt_upd),
    .rule_wr   (rule_wr)
  );

  trc_compare_unit u_cmp (
    .code      (cmp_code),
    .value     (cmp_value),
    .threshold (rd_rule.threshold),
    .pass      (pass)
  );

  always_comb begin
    state_nxt      = state_r;
    rix_nxt        = rix_r;
    pend_valid_nxt = pend_valid_r;
    pend_rule_nxt  = pend_rule_r;
    pend_thr_nxt   = pend_thr_r;
    out_load       = 1'b0;
    out_nxt                 = '0;
    out_nxt.result_kind     = trc_pkg::KIND_EVENT;
    out_nxt.event_pid       = item_r.caller_pid;
    out_nxt.event_rule      = pend_rule_r;
    out_nxt.event_observed  = item_r.byte_count;
    out_nxt.event_threshold = pend_thr_r;
    out_nxt.event_time      = item_r.now_ns;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rix_nxt        = '0;
          pend_valid_nxt = 1'b0;
          if (in_port.data.opcode == trc_pkg::OP_WRITE_CHECK) begin
            state_nxt = ST_WALK;
          end else if (in_port.data.opcode == trc_pkg::OP_READ_COUNT) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (hit && fail) begin
            out_load       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_rule_nxt  = rix_r;
            pend_thr_nxt   = rd_rule.threshold;
          end
          if (rix_r == LAST_RULE) begin
            state_nxt = ST_FLUSH;
          end else begin
            rix_nxt = rix_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_load            = 1'b1;
          out_nxt.last_result = 1'b1;
          pend_valid_nxt      = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_nxt         = '0;
          out_nxt.result_kind     = trc_pkg::KIND_READBACK;
          out_nxt.read_checks     = rd_checks;
          out_nxt.read_violations = rd_viols;
          out_nxt.last_result     = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_port.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rix_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rix_r        <= rix_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_port.data;
    end
    pend_rule_r <= pend_rule_nxt;
    pend_thr_r  <= pend_thr_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/trc_compare_unit.sv @@
// ----------------------------------------------------------------------------
// trc_compare_unit
// Shared signed comparator: tests observed value against a rule threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_compare_unit (
  input  wire logic [2:0]         code,
  input  wire logic signed [63:0] value,
  input  wire logic signed [63:0] threshold,
  output logic                    pass
);

  logic lt;
  logic eq;

  assign lt = value < threshold;
  assign eq = value == threshold;

  always_comb begin
    unique case (code)
      trc_pkg::CMP_LT: pass = lt;
      trc_pkg::CMP_LE: pass = lt | eq;
      trc_pkg::CMP_EQ: pass = eq;
      trc_pkg::CMP_GT: pass = !(lt | eq);
      trc_pkg::CMP_GE: pass = !lt;
      trc_pkg::CMP_NE: pass = !eq;
      default:         pass = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ src/trc_rule_table.sv @@
// ----------------------------------------------------------------------------
// trc_rule_table
// Rule storage with per-rule check and violation counters, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_rule_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [trc_pkg::RULE_IDX_W-1:0] rd_addr,
  output trc_pkg::rule_t                      rd_rule,
  output logic [63:0]                         rd_checks,
  output logic [63:0]                         rd_viols,
  input  wire trc_pkg::cnt_upd_t              cnt_upd,
  input  wire trc_pkg::rule_wr_t              rule_wr
);

  trc_pkg::rule_t rules_r  [trc_pkg::RULE_COUNT];
  logic [63:0]    checks_r [trc_pkg::RULE_COUNT];
  logic [63:0]    viols_r  [trc_pkg::RULE_COUNT];

  assign rd_rule   = rules_r[rd_addr];
  assign rd_checks = checks_r[rd_addr];
  assign rd_viols  = viols_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < trc_pkg::RULE_COUNT; k++) begin
        rules_r[k]  <= '0;
        checks_r[k] <= '0;
        viols_r[k]  <= '0;
      end
    end else begin
      if (rule_wr.en) begin
        rules_r[rule_wr.addr] <= rule_wr.rule;
      end
      if (cnt_upd.inc_check) begin
        checks_r[rd_addr] <= rd_checks + 64'd1;
      end
      if (cnt_upd.inc_viol) begin
        viols_r[rd_addr] <= rd_viols + 64'd1;
      end
    end
  end

endmodule

`default_nettype wire
